@@ rtl/tss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared widths, sequencer states and the reciprocal table for the
// fixed-point Taylor sine unit.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int MAX_ORDER   = 63;
    localparam int ANGLE_W     = 32;
    localparam int ORDER_W     = 6;
    localparam int RESULT_W    = 32;
    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int MAX_TERMS   = (MAX_ORDER + 1) / 2;
    localparam int TERM_IDX_W  = $clog2(MAX_TERMS);
    localparam int CNT_W       = TERM_IDX_W + 1;
    localparam int TERM_SHIFT  = 20;
    localparam int OUT_SHIFT   = 24;
    localparam int X2_SHIFT    = 56;
    localparam int Q_W         = WORD_W - OUT_SHIFT;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_MUL_X2,
        S_MUL_RECIP,
        S_MAG,
        S_OUT
    } t_state;

    // floor((2^64 - 1) / ((2k+2)(2k+3))) for term index k
    localparam logic [WORD_W-1:0] RECIP [MAX_TERMS] = '{
        ALL_ONES / 64'd6,    ALL_ONES / 64'd20,   ALL_ONES / 64'd42,
        ALL_ONES / 64'd72,   ALL_ONES / 64'd110,  ALL_ONES / 64'd156,
        ALL_ONES / 64'd210,  ALL_ONES / 64'd272,  ALL_ONES / 64'd342,
        ALL_ONES / 64'd420,  ALL_ONES / 64'd506,  ALL_ONES / 64'd600,
        ALL_ONES / 64'd702,  ALL_ONES / 64'd812,  ALL_ONES / 64'd930,
        ALL_ONES / 64'd1056, ALL_ONES / 64'd1190, ALL_ONES / 64'd1332,
        ALL_ONES / 64'd1482, ALL_ONES / 64'd1640, ALL_ONES / 64'd1806,
        ALL_ONES / 64'd1980, ALL_ONES / 64'd2162, ALL_ONES / 64'd2352,
        ALL_ONES / 64'd2550, ALL_ONES / 64'd2756, ALL_ONES / 64'd2970,
        ALL_ONES / 64'd3192, ALL_ONES / 64'd3422, ALL_ONES / 64'd3660,
        ALL_ONES / 64'd3906, ALL_ONES / 64'd4160
    };

endpackage
`default_nettype wire

@@ rtl/tss_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tss_mul
// 64x64 -> 128 unsigned multiplier built on one 32x32 multiplier,
// four partial products accumulated over successive cycles.
// ----------------------------------------------------------------------------
module tss_mul
    import tss_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [WORD_W-1:0]   i_a,
    input  wire logic [WORD_W-1:0]   i_b,
    output logic                     o_done,
    output logic [PROD_W-1:0]        o_prod
);

    logic                r_busy;
    logic [1:0]          r_step;
    logic                r_pp_vld;
    logic                r_pp_last;
    logic [1:0]          r_pp_pos;
    logic [WORD_W-1:0]   r_pp;
    logic [PROD_W-1:0]   r_acc;
    logic                r_done;

    logic [HALF_W-1:0]   w_a_part;
    logic [HALF_W-1:0]   w_b_part;
    logic [1:0]          w_pos;
    logic [PROD_W-1:0]   w_pp_shifted;

    always_comb begin
        w_a_part     = r_step[1] ? i_a[WORD_W-1:HALF_W] : i_a[HALF_W-1:0];
        w_b_part     = r_step[0] ? i_b[WORD_W-1:HALF_W] : i_b[HALF_W-1:0];
        w_pos        = {1'b0, r_step[1]} + {1'b0, r_step[0]};
        w_pp_shifted = {{(PROD_W-WORD_W){1'b0}}, r_pp} << (r_pp_pos * HALF_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_step    <= '0;
            r_pp_vld  <= 1'b0;
            r_pp_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pp_vld  <= r_busy;
            r_pp_last <= r_busy && (r_step == 2'd3);
            r_done    <= r_pp_vld && r_pp_last;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp     <= w_a_part * w_b_part;
        r_pp_pos <= w_pos;
        if (i_start && !r_busy) begin
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + w_pp_shifted;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

@@ rtl/taylor_sine_series.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// taylor_sine_series
// Truncated Taylor sine, Q3.28 angle in, saturated Q7.24 sum out.
// An order gives (order+1)/2 terms; with any terms, the angle is squared once
// and each further term takes two passes through the shared 32x32 multiplier
// (by x^2, then by the reciprocal). One request is in flight at a time; the
// next is taken in the cycle after the result is placed in the output register.
// Reset (synchronous, active low) returns to idle and clears the output valid.
// ----------------------------------------------------------------------------
module taylor_sine_series
    import tss_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [ANGLE_W-1:0]  i_angle,
    input  wire logic [ORDER_W-1:0]         i_order,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [RESULT_W-1:0]      o_sine_value,
    output logic                            o_saturated
);

    t_state                  r_state;
    t_state                  n_state;

    logic                    r_xneg;
    logic [ANGLE_W-1:0]      r_magx;
    logic [CNT_W-1:0]        r_cnt;
    logic [TERM_IDX_W-1:0]   r_k;
    logic [WORD_W-1:0]       r_x2;
    logic [WORD_W-1:0]       r_term;
    logic [WORD_W-1:0]       r_acc;
    logic                    r_sneg;
    logic                    r_o_valid;
    logic [RESULT_W-1:0]     r_sine;
    logic                    r_sat;

    logic                    w_in_fire;
    logic [ANGLE_W-1:0]      w_angle_u;
    logic [ANGLE_W-1:0]      w_magx;
    logic [ORDER_W:0]        w_order_c;
    logic [ORDER_W:0]        w_order_p1;
    logic [CNT_W-1:0]        w_cnt;
    logic                    w_more;
    logic                    w_tneg;
    logic                    w_mul_start;
    logic                    w_out_load;
    logic [WORD_W-1:0]       w_mul_a;
    logic [WORD_W-1:0]       w_mul_b;
    logic                    w_mul_done;
    logic [PROD_W-1:0]       w_prod;
    logic [WORD_W-1:0]       w_v;
    logic [WORD_W-1:0]       w_rnd;
    logic [Q_W-1:0]          w_q;
    logic [RESULT_W-1:0]     w_res;
    logic                    w_res_sat;

    tss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        w_angle_u  = i_angle;
        w_magx     = w_angle_u[ANGLE_W-1] ? (~w_angle_u + ANGLE_W'(1)) : w_angle_u;
        w_order_c  = ({1'b0, i_order} > (ORDER_W+1)'(MAX_ORDER)) ?
                     (ORDER_W+1)'(MAX_ORDER) : {1'b0, i_order};
        w_order_p1 = w_order_c + (ORDER_W+1)'(1);
        w_cnt      = CNT_W'(w_order_p1 >> 1);
        w_in_fire  = i_valid && o_ready;
        w_more     = ({1'b0, r_k} + CNT_W'(1)) < r_cnt;
        w_tneg     = r_xneg ^ r_k[0];
        w_v        = (w_prod[PROD_W-1:X2_SHIFT+WORD_W] != '0) ?
                     ALL_ONES : w_prod[X2_SHIFT+WORD_W-1:X2_SHIFT];
        w_rnd      = r_acc + (WORD_W'(1) << (OUT_SHIFT - 1));
        w_q        = w_rnd[WORD_W-1:OUT_SHIFT];
        if (r_sneg) begin
            w_res_sat = w_q > (Q_W'(1) << (RESULT_W - 1));
            w_res     = w_res_sat ? (RESULT_W'(1) << (RESULT_W - 1)) :
                        (~w_q[RESULT_W-1:0] + RESULT_W'(1));
        end else begin
            w_res_sat = w_q > ((Q_W'(1) << (RESULT_W - 1)) - Q_W'(1));
            w_res     = w_res_sat ? ((RESULT_W'(1) << (RESULT_W - 1)) - RESULT_W'(1)) :
                        w_q[RESULT_W-1:0];
        end
    end

    always_comb begin
        case (r_state)
            S_SQUARE: begin
                w_mul_a = {{(WORD_W-ANGLE_W){1'b0}}, r_magx};
                w_mul_b = {{(WORD_W-ANGLE_W){1'b0}}, r_magx};
            end
            S_MUL_RECIP: begin
                w_mul_a = r_term;
                w_mul_b = RECIP[r_k];
            end
            default: begin
                w_mul_a = r_term;
                w_mul_b = r_x2;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (w_cnt == '0) ? S_MAG : S_SQUARE;
                end
            end
            S_SQUARE: begin
                if (w_mul_done) begin
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                n_state = w_more ? S_MUL_X2 : S_MAG;
            end
            S_MUL_X2: begin
                if (w_mul_done) begin
                    n_state = S_MUL_RECIP;
                end
            end
            S_MUL_RECIP: begin
                if (w_mul_done) begin
                    n_state = S_ACCUM;
                end
            end
            S_MAG: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        w_mul_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                w_mul_start = i_valid && (w_cnt != '0);
            end
            S_ACCUM: begin
                w_mul_start = w_more;
            end
            S_MUL_X2: begin
                w_mul_start = w_mul_done;
            end
            S_OUT: begin
                w_out_load = !r_o_valid || i_ready;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    r_xneg <= w_angle_u[ANGLE_W-1];
                    r_magx <= w_magx;
                    r_cnt  <= w_cnt;
                    r_acc  <= '0;
                end
            end
            S_SQUARE: begin
                if (w_mul_done) begin
                    r_x2   <= w_prod[WORD_W-1:0];
                    r_term <= {{(WORD_W-ANGLE_W){1'b0}}, r_magx} << TERM_SHIFT;
                    r_k    <= '0;
                end
            end
            S_ACCUM: begin
                r_acc <= w_tneg ? (r_acc - r_term) : (r_acc + r_term);
            end
            S_MUL_X2: begin
                if (w_mul_done) begin
                    r_term <= w_v;
                end
            end
            S_MUL_RECIP: begin
                if (w_mul_done) begin
                    r_term <= w_prod[PROD_W-1:WORD_W];
                    r_k    <= r_k + TERM_IDX_W'(1);
                end
            end
            S_MAG: begin
                r_sneg <= r_acc[WORD_W-1];
                r_acc  <= r_acc[WORD_W-1] ? (~r_acc + WORD_W'(1)) : r_acc;
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_sine <= w_res;
                    r_sat  <= w_res_sat;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_valid      = r_o_valid;
    assign o_sine_value = r_sine;
    assign o_saturated  = r_sat;

endmodule
`default_nettype wire

@@ tb/sv/taylor_sine_series_test.sv @@
// ----------------------------------------------------------------------------
// taylor_sine_series_test
// Self-checking bench for the fixed-point Taylor sine unit. A queue of
// requests (directed corner angles and orders, then random ones) feeds a
// valid/ready driver; each accepted request is predicted bit-exactly in
// Q.48 arithmetic and the monitor compares every returned sum and saturation
// flag in order. Both sides idle at random in two phases, then run without idling.
// ----------------------------------------------------------------------------
module taylor_sine_series_test;
    import tss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 500;
    localparam int PHASE_LEN   = 175;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 450;
    localparam int MAX_REPORTS = 10;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 32'h7FFF_FFFF;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN  = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_ONE  = 32'h1000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_PI   = 32'h3243_F6A9;
    localparam logic [ANGLE_W-1:0] ANGLE_PI_2 = 32'h1921_FB54;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic [ORDER_W-1:0] order;
    } t_sine_request;

    typedef struct {
        logic [ANGLE_W-1:0]  angle;
        logic [ORDER_W-1:0]  order;
        logic [RESULT_W-1:0] value;
        logic                sat;
    } t_sine_result;

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       i_valid  = 1'b0;
    logic                       o_ready;
    logic signed [ANGLE_W-1:0]  i_angle  = '0;
    logic [ORDER_W-1:0]         i_order  = '0;
    logic                       o_valid;
    logic                       i_ready  = 1'b0;
    logic signed [RESULT_W-1:0] o_sine_value;
    logic                       o_saturated;

    t_sine_request request_q[$];
    t_sine_result  expected_q[$];
    int            num_sent    = 0;
    int            mismatches  = 0;
    int            idle_cycles = 0;
    int            send_idle_pct;
    int            recv_idle_pct;

    taylor_sine_series DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_angle      (i_angle),
        .i_order      (i_order),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sine_value (o_sine_value),
        .o_saturated  (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sine_result taylor_sine_predict(logic [ANGLE_W-1:0] x,
                                                         logic [ORDER_W-1:0] ord);
        logic [WORD_W-1:0] mag_x, x_sq, term_mag, acc, recip, narrowed, sum_mag, q;
        logic [WORD_W-1:0] denom;
        logic [PROD_W-1:0] prod;
        logic              x_neg, sum_neg;
        int                eff_order, n_terms;
        t_sine_result      r;
        x_neg = x[ANGLE_W-1];
        mag_x = x_neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
        eff_order = (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
        n_terms = (eff_order + 1) / 2;
        x_sq = mag_x * mag_x;
        term_mag = mag_x << TERM_SHIFT;
        acc = '0;
        for (int k = 0; k < n_terms; k++) begin
            acc = (x_neg ^ k[0]) ? acc - term_mag : acc + term_mag;
            if (k + 1 < n_terms) begin
                denom = WORD_W'((2 * k + 2) * (2 * k + 3));
                recip = {WORD_W{1'b1}} / denom;
                prod = {{WORD_W{1'b0}}, term_mag} * {{WORD_W{1'b0}}, x_sq};
                narrowed = (prod[PROD_W-1:X2_SHIFT+WORD_W] != '0) ? {WORD_W{1'b1}}
                                                                   : prod[X2_SHIFT +: WORD_W];
                prod = {{WORD_W{1'b0}}, narrowed} * {{WORD_W{1'b0}}, recip};
                term_mag = prod[PROD_W-1:WORD_W];
            end
        end
        sum_neg = acc[WORD_W-1];
        sum_mag = sum_neg ? -acc : acc;
        q = (sum_mag + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        r.angle = x;
        r.order = ord;
        r.sat = 1'b0;
        if (sum_neg) begin
            if (q > 64'h8000_0000) begin
                q = 64'h8000_0000;
                r.sat = 1'b1;
            end
            r.value = ~q[RESULT_W-1:0] + 1'b1;
        end else begin
            if (q > 64'h7FFF_FFFF) begin
                q = 64'h7FFF_FFFF;
                r.sat = 1'b1;
            end
            r.value = q[RESULT_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        if (num_sent < PHASE_LEN) begin
            send_idle_pct = 20;
            recv_idle_pct = 68;
        end else if (num_sent < 2 * PHASE_LEN) begin
            send_idle_pct = 68;
            recv_idle_pct = 20;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_q.push_back(taylor_sine_predict(i_angle, i_order));
                num_sent <= num_sent + 1;
            end
            if (!i_valid || o_ready) begin
                if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_angle <= request_q[0].angle;
                    i_order <= request_q[0].order;
                    i_valid <= 1'b1;
                    request_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: value %h sat %b",
                                 o_sine_value, o_saturated);
                end else begin
                    if (o_sine_value !== expected_q[0].value ||
                        o_saturated !== expected_q[0].sat) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display("mismatch angle %h order %0d: expected %h/%b got %h/%b",
                                     expected_q[0].angle, expected_q[0].order,
                                     expected_q[0].value, expected_q[0].sat,
                                     o_sine_value, o_saturated);
                    end
                    expected_q.pop_front();
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_sine_request req;
        int            pick;

        request_q.push_back('{'0,         6'd0});
        request_q.push_back('{'0,         6'd63});
        request_q.push_back('{ANGLE_MAX,  6'd0});
        request_q.push_back('{ANGLE_MAX,  6'd1});
        request_q.push_back('{ANGLE_MAX,  6'd3});
        request_q.push_back('{ANGLE_MAX,  6'd5});
        request_q.push_back('{ANGLE_MAX,  6'd7});
        request_q.push_back('{ANGLE_MAX,  6'd63});
        request_q.push_back('{ANGLE_MIN,  6'd1});
        request_q.push_back('{ANGLE_MIN,  6'd3});
        request_q.push_back('{ANGLE_MIN,  6'd5});
        request_q.push_back('{ANGLE_MIN,  6'd63});
        request_q.push_back('{ANGLE_PI_2, 6'd2});
        request_q.push_back('{ANGLE_PI_2, 6'd3});
        request_q.push_back('{-ANGLE_PI_2, 6'd63});
        request_q.push_back('{ANGLE_PI,   6'd62});
        request_q.push_back('{-ANGLE_PI,  6'd9});
        request_q.push_back('{ANGLE_ONE,  6'd63});
        request_q.push_back('{32'h0000_0001, 6'd63});
        request_q.push_back('{32'hFFFF_FFFF, 6'd63});
        request_q.push_back('{32'h4000_0000, 6'd9});
        request_q.push_back('{32'hC000_0000, 6'd12});

        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                req.angle = $urandom;
            end else if (pick < 8) begin
                req.angle = $urandom_range(0, 2 * ANGLE_PI) - ANGLE_PI;
            end else begin
                req.angle = $urandom_range(0, 1) ? ANGLE_MAX - $urandom_range(0, 255)
                                                 : ANGLE_MIN + $urandom_range(0, 255);
            end
            req.order = $urandom_range(0, 63);
            request_q.push_back(req);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
